@@ src/brf_pkg.sv @@
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int LEN_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_HDR  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_PULL = 2'd2,
    REQ_PEEK = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_PUSH_OK      = 2'd0,
    ST_PUSH_REFUSED = 2'd1,
    ST_BYTE         = 2'd2,
    ST_NONE         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
    logic [CNT_W-1:0]   grant;
    logic [CNT_W-1:0]   fill;
  } cmd_t;

endpackage

@@ src/brf_front.sv @@
// ----------------------------------------------------------------------------
// brf_front
// Accepts requests, keeps fill and reservation bookkeeping, issues commands.
// ----------------------------------------------------------------------------
module brf_front #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       q_full,
  input  logic [1:0]                 req_type,
  input  logic [brf_pkg::LEN_W-1:0]  req_len,
  input  logic [brf_pkg::BYTE_W-1:0] data_byte,
  output logic                       cmd_push,
  output brf_pkg::cmd_t              cmd
);
  import brf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [CNT_W-1:0] pending_r, pending_nxt;

  logic             accept;
  req_t             rtype;
  logic [LEN_W-1:0] used;
  logic [LEN_W-1:0] space;
  logic [CNT_W-1:0] grant;
  logic [CNT_W-1:0] rsum;

  assign accept   = push && !q_full;
  assign cmd_push = accept;
  assign rtype    = req_t'(req_type);
  assign used     = LEN_W'(stored_r) + LEN_W'(pending_r);
  assign space    = LEN_W'(DEPTH) - used;
  assign grant    = (req_len > LEN_W'(stored_r)) ? stored_r : CNT_W'(req_len);
  assign rsum     = CNT_W'(rptr_r) + grant;

  always_comb begin
    wptr_nxt    = wptr_r;
    rptr_nxt    = rptr_r;
    stored_nxt  = stored_r;
    pending_nxt = pending_r;
    cmd.kind    = CMD_STATUS;
    cmd.status  = ST_PUSH_REFUSED;
    cmd.addr    = '0;
    cmd.data    = '0;
    cmd.grant   = '0;
    cmd.fill    = stored_r;
    case (rtype)
      REQ_HDR: begin
        if (pending_r == '0 && req_len <= space) begin
          cmd.status  = ST_PUSH_OK;
          pending_nxt = CNT_W'(req_len);
        end
      end
      REQ_DATA: begin
        if (pending_r != '0) begin
          cmd.kind    = CMD_WRITE;
          cmd.status  = ST_PUSH_OK;
          cmd.addr    = ADDR_W'(wptr_r);
          cmd.data    = data_byte;
          cmd.fill    = stored_r + CNT_W'(1);
          stored_nxt  = stored_r + CNT_W'(1);
          pending_nxt = pending_r - CNT_W'(1);
          wptr_nxt    = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
        end
      end
      REQ_PULL, REQ_PEEK: begin
        if (grant == '0) begin
          cmd.status = ST_NONE;
        end else begin
          cmd.kind   = CMD_READ;
          cmd.status = ST_BYTE;
          cmd.addr   = ADDR_W'(rptr_r);
          cmd.grant  = grant;
          if (rtype == REQ_PULL) begin
            cmd.fill   = stored_r - grant;
            stored_nxt = stored_r - grant;
            rptr_nxt   = (rsum >= CNT_W'(DEPTH)) ? PTR_W'(rsum - CNT_W'(DEPTH))
                                                 : PTR_W'(rsum);
          end
        end
      end
      default: begin
        cmd.status = ST_PUSH_REFUSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r    <= '0;
      rptr_r    <= '0;
      stored_r  <= '0;
      pending_r <= '0;
    end else if (accept) begin
      wptr_r    <= wptr_nxt;
      rptr_r    <= rptr_nxt;
      stored_r  <= stored_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ src/brf_cmd_q.sv @@
// ----------------------------------------------------------------------------
// brf_cmd_q
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module brf_cmd_q #(
  parameter int DEPTH = brf_pkg::CMDQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  brf_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output brf_pkg::cmd_t rd_cmd,
  output logic          q_full,
  output logic          q_empty
);
  import brf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CT_W  = $clog2(DEPTH + 1);

  cmd_t              slot_r [DEPTH];
  logic [IDX_W-1:0]  wptr_r;
  logic [IDX_W-1:0]  rptr_r;
  logic [CT_W-1:0]   count_r;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count_r == CT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == IDX_W'(DEPTH - 1)) ? '0 : wptr_r + IDX_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == IDX_W'(DEPTH - 1)) ? '0 : rptr_r + IDX_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + CT_W'(1);
        2'b01:   count_r <= count_r - CT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/brf_back.sv @@
// ----------------------------------------------------------------------------
// brf_back
// Executes commands: writes, byte-per-cycle reads unless pop stalls, out reg.
// ----------------------------------------------------------------------------
module brf_back #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  brf_pkg::cmd_t               cmd,
  input  logic                        cmd_valid,
  output logic                        cmd_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [1:0]                  status,
  output logic [brf_pkg::BYTE_W-1:0]  out_byte,
  output logic [brf_pkg::CNT_W-1:0]   granted_count,
  output logic [brf_pkg::CNT_W-1:0]   fill_level,
  output logic                        last
);
  import brf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic              out_valid_r;
  status_t           out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [CNT_W-1:0]  out_grant_r;
  logic [CNT_W-1:0]  out_fill_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  idx_r;
  logic [PTR_W-1:0]  addr_r;

  logic              advance;
  logic              fire;
  logic              is_read;
  logic              is_write;
  logic [PTR_W-1:0]  raddr;
  logic              rd_last;
  logic              res_last;

  assign advance  = !out_valid_r || pop;
  assign fire     = advance && cmd_valid;
  assign is_read  = (cmd.kind == CMD_READ);
  assign is_write = (cmd.kind == CMD_WRITE);
  assign raddr    = (idx_r == '0) ? cmd.addr[PTR_W-1:0] : addr_r;
  assign rd_last  = (idx_r + CNT_W'(1) == cmd.grant);
  assign res_last = is_read ? rd_last : 1'b1;
  assign cmd_pop  = fire && res_last;

  always_ff @(posedge clk) begin
    if (fire && is_write) begin
      mem[cmd.addr[PTR_W-1:0]] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r   <= is_read ? mem[raddr] : '0;
      out_status_r <= cmd.status;
      out_grant_r  <= cmd.grant;
      out_fill_r   <= cmd.fill;
      out_last_r   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      addr_r      <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= cmd_valid;
      end
      if (fire && is_read) begin
        idx_r  <= rd_last ? '0 : idx_r + CNT_W'(1);
        addr_r <= (raddr == PTR_W'(DEPTH - 1)) ? '0 : raddr + PTR_W'(1);
      end
    end
  end

  assign empty         = !out_valid_r;
  assign status        = out_status_r;
  assign out_byte      = out_byte_r;
  assign granted_count = out_grant_r;
  assign fill_level    = out_fill_r;
  assign last          = out_last_r;

endmodule

@@ src/byte_ring_fifo.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Circular byte FIFO with reserved pushes, pulls and peeks.
// ----------------------------------------------------------------------------
// Requests enter through push/full: a beat is taken when push is high and
// full is low. A push header reserves bytes, push data beats store them, and
// a pull or peek returns up to the stored count, one result beat per byte.
// Results leave through empty/pop: the oldest result sits on the out_ ports
// while empty is low and is taken when pop is high.
// Header, data and zero-grant requests give one result; a pull or peek of N
// bytes gives N results, the last one flagged.
// The front takes one request per cycle while full is low into a 4-entry
// command queue. With the queue and the back idle, a request's first result
// passes the queue slot and then the single output register before it is on
// the out_ ports. A read of N bytes holds the back until its N result beats
// are out; the back drains one result beat per cycle while pop keeps up, and
// full rises once the command queue is backed up behind reads.
// When pop stays low the output register holds, the back stops, and the
// queue fills. Synchronous reset empties the FIFO, clears the reservation
// and drops all queued results; byte storage is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_fifo #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_req_type,
  input  logic [brf_pkg::LEN_W-1:0]   in_req_len,
  input  logic [brf_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  out_status,
  output logic [brf_pkg::BYTE_W-1:0]  out_byte,
  output logic [brf_pkg::CNT_W-1:0]   out_granted_count,
  output logic [brf_pkg::CNT_W-1:0]   out_fill_level,
  output logic                        out_last
);
  import brf_pkg::*;

  cmd_t f_cmd;
  cmd_t q_cmd;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic b_pop;

  assign full = q_full;

  brf_front #(.DEPTH(DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_full    (q_full),
    .req_type  (in_req_type),
    .req_len   (in_req_len),
    .data_byte (in_data_byte),
    .cmd_push  (f_push),
    .cmd       (f_cmd)
  );

  brf_cmd_q #(.DEPTH(CMDQ_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_cmd  (f_cmd),
    .rd_en   (b_pop),
    .rd_cmd  (q_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  brf_back #(.DEPTH(DEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (q_cmd),
    .cmd_valid     (!q_empty),
    .cmd_pop       (b_pop),
    .pop           (pop),
    .empty         (empty),
    .status        (out_status),
    .out_byte      (out_byte),
    .granted_count (out_granted_count),
    .fill_level    (out_fill_level),
    .last          (out_last)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_fill_level <= CNT_W'(DEPTH))
    else $error("fill level above depth");

  a_byte_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_BYTE) |-> (out_granted_count != '0))
    else $error("byte beat with zero grant");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_BYTE) |-> out_last)
    else $error("non-byte beat without last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results present after reset");

endmodule
